// ----- hdl/a2y_pkg.sv -----
// Shared constants, types and helpers for the ARGB to YUV 4:2:0 converter.
package a2y_pkg;

   // Frame geometry
   localparam int MAX_DIM = 4096;
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = CNT_W + 1;
   localparam int CSR_W   = 13;
   localparam int IDX_W   = 2;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_FRAME_WIDTH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] CSR_FRAME_HEIGHT = IDX_W'(1);

   // Register reset values
   localparam logic [CSR_W-1:0] WIDTH_RESET  = CSR_W'(640);
   localparam logic [CSR_W-1:0] HEIGHT_RESET = CSR_W'(480);

   // BT.601 studio-range coefficients (scaled by 256)
   localparam int Y_KR  = 66;
   localparam int Y_KG  = 129;
   localparam int Y_KB  = 25;
   localparam int CB_KR = -38;
   localparam int CB_KG = -74;
   localparam int CB_KB = 112;
   localparam int CR_KR = 112;
   localparam int CR_KG = -94;
   localparam int CR_KB = -18;
   localparam int ROUND_BIAS   = 128;
   localparam int LUMA_OFFSET  = 16;
   localparam int CHROMA_OFFSET = 128;

   // Color components of one pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // Converted values of one pixel
   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } ycc_type;

   // Clear the low bit and clamp a size register into 2..MAX_DIM (even)
   function automatic logic [DIM_W-1:0] effective_size(input logic [CSR_W-1:0] reg_value);
      logic [CSR_W-1:0] even_value;
      logic [CSR_W-1:0] limit;
      logic [DIM_W-1:0] result;
      even_value = reg_value & ~CSR_W'(1);
      limit      = CSR_W'(MAX_DIM) & ~CSR_W'(1);
      if (even_value < CSR_W'(2)) begin
         result = DIM_W'(2);
      end else if (even_value > limit) begin
         result = DIM_W'(limit);
      end else begin
         result = DIM_W'(even_value);
      end
      return result;
   endfunction

endpackage

// ----- hdl/a2y_csc.sv -----
// BT.601 color space conversion of one pixel: luma always, chroma when flagged.
module a2y_csc (
   input  a2y_pkg::rgb_type pixel,
   input  logic             chroma_valid,
   output a2y_pkg::ycc_type ycc
);
   import a2y_pkg::*;

   logic [15:0]        luma_sum;
   logic signed [17:0] red_s;
   logic signed [17:0] green_s;
   logic signed [17:0] blue_s;
   logic signed [17:0] cb_acc;
   logic signed [17:0] cr_acc;
   logic signed [17:0] cb_adj;
   logic signed [17:0] cr_adj;
   logic signed [17:0] cb_quot;
   logic signed [17:0] cr_quot;

   // Luma: unsigned weighted sum, rounded, then offset
   assign luma_sum = 16'(Y_KR * int'(pixel.red)) + 16'(Y_KG * int'(pixel.green))
                   + 16'(Y_KB * int'(pixel.blue)) + 16'(ROUND_BIAS);
   assign ycc.luma = luma_sum[15:8] + 8'(LUMA_OFFSET);

   // Chroma: signed weighted sums
   assign red_s   = $signed({10'b0, pixel.red});
   assign green_s = $signed({10'b0, pixel.green});
   assign blue_s  = $signed({10'b0, pixel.blue});

   assign cb_acc = 18'(CB_KR * red_s) + 18'(CB_KG * green_s) + 18'(CB_KB * blue_s)
                 + 18'(ROUND_BIAS);
   assign cr_acc = 18'(CR_KR * red_s) + 18'(CR_KG * green_s) + 18'(CR_KB * blue_s)
                 + 18'(ROUND_BIAS);

   // Divide by 256 truncating toward zero: bias negative sums before the shift
   assign cb_adj  = cb_acc + (cb_acc[17] ? 18'sd255 : 18'sd0);
   assign cr_adj  = cr_acc + (cr_acc[17] ? 18'sd255 : 18'sd0);
   assign cb_quot = cb_adj >>> 8;
   assign cr_quot = cr_adj >>> 8;

   // Neutral chroma where the pixel carries none
   assign ycc.chroma_blue = chroma_valid ? cb_quot[7:0] + 8'(CHROMA_OFFSET)
                                         : 8'(CHROMA_OFFSET);
   assign ycc.chroma_red  = chroma_valid ? cr_quot[7:0] + 8'(CHROMA_OFFSET)
                                         : 8'(CHROMA_OFFSET);

endmodule

// ----- hdl/argb_to_yuv420_converter.sv -----
// Top level: ARGB pixel stream in, BT.601 YCbCr 4:2:0 values out.
//
//   channel  | ports                       | direction | content
//   request  | req_valid/req_stall/req_*   | in        | one ARGB pixel
//   response | rsp_valid/rsp_stall/rsp_*   | out       | Y, Cb/Cr flag and values, frame end
//   control  | csr_write/csr_index/csr_data| in        | frame width and height
//
// One pixel per clock while the response side does not stall; a taken pixel passes through
// the input register, then conversion into the result register. The position counters advance
// when a request is taken. Reset is synchronous and restores 640x480 with the counters at
// zero. A stall on the response side holds both stages; requests keep flowing while
// either stage has room.
module argb_to_yuv420_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_pixel_argb,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_luma,
   output logic                        rsp_chroma_valid,
   output logic [7:0]                  rsp_chroma_blue,
   output logic [7:0]                  rsp_chroma_red,
   output logic                        rsp_frame_end,
   input  logic                        csr_write,
   input  logic [a2y_pkg::IDX_W-1:0]   csr_index,
   input  logic [a2y_pkg::CSR_W-1:0]   csr_data
);
   import a2y_pkg::*;

   logic [CSR_W-1:0] width_ff,  width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic [CNT_W-1:0] col_ff,    col_in;
   logic [CNT_W-1:0] row_ff,    row_in;

   logic             s1_valid_ff, s1_valid_in;
   rgb_type          s1_pixel_ff, s1_pixel_in;
   logic             s1_chroma_ff, s1_chroma_in;
   logic             s1_last_ff,  s1_last_in;

   logic             out_valid_ff, out_valid_in;
   ycc_type          out_ycc_ff,   out_ycc_in;
   logic             out_chroma_ff, out_chroma_in;
   logic             out_last_ff,  out_last_in;

   logic [DIM_W-1:0] width_eff;
   logic [DIM_W-1:0] height_eff;
   logic             req_take;
   logic             out_load;
   logic             row_done;
   logic             frame_last;
   ycc_type          ycc;

   // Handshake: the result register loads when empty or drained
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   // Register writes, unknown indexes dropped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // Raster position of the incoming pixel
   assign width_eff  = effective_size(width_ff);
   assign height_eff = effective_size(height_ff);
   assign row_done   = ({1'b0, col_ff} + DIM_W'(1)) >= width_eff;
   assign frame_last = row_done && (({1'b0, row_ff} + DIM_W'(1)) >= height_eff);

   // Advance counters on each accepted request
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_take) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
         end else if (row_done) begin
            col_in = '0;
            row_in = row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
   end

   // Input stage: capture the pixel and its position flags
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_pixel_in  = s1_pixel_ff;
      s1_chroma_in = s1_chroma_ff;
      s1_last_in   = s1_last_ff;
      if (req_take) begin
         s1_valid_in       = 1'b1;
         s1_pixel_in.red   = req_pixel_argb[23:16];
         s1_pixel_in.green = req_pixel_argb[15:8];
         s1_pixel_in.blue  = req_pixel_argb[7:0];
         s1_chroma_in      = !col_ff[0] && !row_ff[0];
         s1_last_in        = frame_last;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   a2y_csc u_csc (
      .pixel        (s1_pixel_ff),
      .chroma_valid (s1_chroma_ff),
      .ycc          (ycc)
   );

   // Result stage: load converted values when there is room
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_ycc_in    = out_ycc_ff;
      out_chroma_in = out_chroma_ff;
      out_last_in   = out_last_ff;
      if (out_load) begin
         out_valid_in  = s1_valid_ff;
         out_ycc_in    = ycc;
         out_chroma_in = s1_chroma_ff;
         out_last_in   = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_pixel_ff   <= s1_pixel_in;
      s1_chroma_ff  <= s1_chroma_in;
      s1_last_ff    <= s1_last_in;
      out_ycc_ff    <= out_ycc_in;
      out_chroma_ff <= out_chroma_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_ycc_ff.luma;
   assign rsp_chroma_valid = out_chroma_ff;
   assign rsp_chroma_blue  = out_ycc_ff.chroma_blue;
   assign rsp_chroma_red   = out_ycc_ff.chroma_red;
   assign rsp_frame_end    = out_last_ff;

endmodule

// ----- sim/tb.sv -----
// Testbench for argb_to_yuv420_converter: directed and random pixel frames against a predictor.
`timescale 1ns / 1ps

module tb;

   // Unused register indexes, writes to them must be ignored
   localparam logic [a2y_pkg::IDX_W-1:0] CSR_SPARE_LOW  = a2y_pkg::IDX_W'(2);
   localparam logic [a2y_pkg::IDX_W-1:0] CSR_SPARE_HIGH = a2y_pkg::IDX_W'(3);

   // BT.601 studio-range coefficients, scaled by 256
   localparam int LUMA_R   = 66;
   localparam int LUMA_G   = 129;
   localparam int LUMA_B   = 25;
   localparam int BLUE_R   = -38;
   localparam int BLUE_G   = -74;
   localparam int BLUE_B   = 112;
   localparam int RED_R    = 112;
   localparam int RED_G    = -94;
   localparam int RED_B    = -18;
   localparam int HALF_LSB = 128;
   localparam int LARGEST  = 4096;

   typedef struct {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       frame_end;
   } pixel_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [31:0]                  req_pixel_argb = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [7:0]                   rsp_luma;
   logic                         rsp_chroma_valid;
   logic [7:0]                   rsp_chroma_blue;
   logic [7:0]                   rsp_chroma_red;
   logic                         rsp_frame_end;
   logic                         csr_write = 1'b0;
   logic [a2y_pkg::IDX_W-1:0]    csr_index = '0;
   logic [a2y_pkg::CSR_W-1:0]    csr_data = '0;

   // Predictor state: size settings and position of the next pixel
   logic [a2y_pkg::CSR_W-1:0]    width_setting = a2y_pkg::CSR_W'(640);
   logic [a2y_pkg::CSR_W-1:0]    height_setting = a2y_pkg::CSR_W'(480);
   int unsigned                  col_pos = 0;
   int unsigned                  row_pos = 0;

   pixel_result_type             expected_pixels[$];
   int                           mismatch_count = 0;
   int                           burst_left = 0;
   int                           stall_mode = 0;
   int                           stall_timer = 0;

   argb_to_yuv420_converter uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_argb   (req_pixel_argb),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_chroma_blue  (rsp_chroma_blue),
      .rsp_chroma_red   (rsp_chroma_red),
      .rsp_frame_end    (rsp_frame_end),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Frame dimension in use for a size setting: even, at least 2, at most the largest size
   function automatic int unsigned active_size(input logic [a2y_pkg::CSR_W-1:0] setting);
      int unsigned even_size;
      even_size = 32'({setting[a2y_pkg::CSR_W-1:1], 1'b0});
      if (even_size < 2) begin
         even_size = 2;
      end else if (even_size > LARGEST) begin
         even_size = LARGEST;
      end
      return even_size;
   endfunction

   // Convert one pixel at the current position, then advance the position
   function automatic pixel_result_type convert_pixel(input logic [31:0] px);
      pixel_result_type res;
      int            red;
      int            green;
      int            blue;
      int unsigned   frame_w;
      int unsigned   frame_h;
      logic          row_done;
      red   = int'(px[23:16]);
      green = int'(px[15:8]);
      blue  = int'(px[7:0]);
      frame_w = active_size(width_setting);
      frame_h = active_size(height_setting);
      row_done = (col_pos + 1 >= frame_w);
      res.chroma_valid = !col_pos[0] && !row_pos[0];
      res.frame_end    = row_done && (row_pos + 1 >= frame_h);
      res.luma = 8'((LUMA_R * red + LUMA_G * green + LUMA_B * blue + HALF_LSB) / 256 + 16);
      res.chroma_blue = 8'(128);
      res.chroma_red  = 8'(128);
      // Signed division truncates toward zero here
      if (res.chroma_valid) begin
         res.chroma_blue = 8'((BLUE_R * red + BLUE_G * green + BLUE_B * blue + HALF_LSB) / 256
                              + 128);
         res.chroma_red  = 8'((RED_R * red + RED_G * green + RED_B * blue + HALF_LSB) / 256
                              + 128);
      end
      if (res.frame_end) begin
         col_pos = 0;
         row_pos = 0;
      end else if (row_done) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return res;
   endfunction

   // Pixels still to come up to and including the next frame end
   function automatic int unsigned pixels_left();
      int unsigned frame_w;
      int unsigned frame_h;
      int unsigned row_rest;
      frame_w = active_size(width_setting);
      frame_h = active_size(height_setting);
      row_rest = (col_pos + 1 >= frame_w) ? 1 : frame_w - col_pos;
      if (row_pos + 1 >= frame_h) begin
         return row_rest;
      end
      return row_rest + (frame_h - row_pos - 1) * frame_w;
   endfunction

   // Pixel with channels often at their extremes
   function automatic logic [31:0] random_pixel();
      logic [31:0] px;
      px = $urandom;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 4))
            0: px[ch*8 +: 8] = 8'h00;
            1: px[ch*8 +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return px;
   endfunction

   // Send one pixel request, idling between bursts, and record its expected result
   task automatic send_pixel(input logic [31:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_pixel_argb <= px;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      expected_pixels.push_back(convert_pixel(px));
   endtask

   // Hold off requests until every result is back and the pipeline has drained
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [a2y_pkg::IDX_W-1:0] idx,
                                 input logic [a2y_pkg::CSR_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         a2y_pkg::CSR_FRAME_WIDTH:  width_setting = value;
         a2y_pkg::CSR_FRAME_HEIGHT: height_setting = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_random_pixels(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // Color extremes at reset size, first row
   task automatic test_color_extremes();
      logic [31:0] corners [16] = '{
         32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
         32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'h00FF_FF00,
         32'h0000_FFFF, 32'h00FF_00FF, 32'h0080_8080, 32'h0001_0101,
         32'h00FE_FEFE, 32'hA512_3456, 32'h5AED_CBA9, 32'h00FF_FF00};
      foreach (corners[i]) send_pixel(corners[i]);
   endtask

   // Reset width wraps at 640; narrowing mid-frame then runs out the reset height of 480
   task automatic test_reset_size();
      send_random_pixels(640 - 16 + 2);
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(2));
      send_random_pixels(pixels_left() + 3);
   endtask

   // Sizes below 2 are raised to 2
   task automatic test_minimum_size();
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, '0);
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, '0);
      send_random_pixels(pixels_left() + 8);
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(1));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(1));
      send_random_pixels(8);
   endtask

   // Odd sizes drop their low bit
   task automatic test_odd_size();
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(7));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(5));
      send_random_pixels(pixels_left() + 24);
   endtask

   // Writes to unused indexes leave the frame size alone
   task automatic test_unused_index();
      wait_idle();
      write_register(CSR_SPARE_LOW, a2y_pkg::CSR_W'(4));
      write_register(CSR_SPARE_HIGH, '1);
      send_random_pixels(30);
   endtask

   // Shrink the frame below the current position
   task automatic test_shrink_mid_frame();
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(12));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(10));
      send_random_pixels(pixels_left() + 12 * 5 + 9);
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(4));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(4));
      send_random_pixels(17);
      // Height only: the row in progress finishes, then the frame ends
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(8));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(8));
      send_random_pixels(pixels_left() + 8 * 6 + 2);
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(2));
      send_random_pixels(14);
   endtask

   // All-ones settings clamp to the largest size: a short run goes on without a wrap,
   // then a small frame closes it out
   task automatic test_largest_size();
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, '1);
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, '1);
      send_random_pixels(40);
      wait_idle();
      write_register(a2y_pkg::CSR_FRAME_WIDTH, a2y_pkg::CSR_W'(2));
      write_register(a2y_pkg::CSR_FRAME_HEIGHT, a2y_pkg::CSR_W'(2));
      send_random_pixels(pixels_left() + 2);
   endtask

   // Random sizes, mostly whole frames, with changes between phases
   task automatic test_random_frames();
      int unsigned sent;
      int unsigned phase_len;
      int unsigned left;
      logic [a2y_pkg::IDX_W-1:0] idx;
      logic [a2y_pkg::CSR_W-1:0] value;
      sent = 0;
      while (sent < 300) begin
         wait_idle();
         repeat ($urandom_range(0, 2)) begin
            idx = a2y_pkg::IDX_W'($urandom_range(0, 3));
            value = ($urandom_range(0, 4) == 0) ? a2y_pkg::CSR_W'($urandom_range(0, 8191))
                                                : a2y_pkg::CSR_W'($urandom_range(0, 24));
            write_register(idx, value);
         end
         left = pixels_left();
         if ($urandom_range(0, 9) < 7) begin
            phase_len = (left <= 150) ? left + $urandom_range(0, 1) * $urandom_range(1, 20)
                                      : $urandom_range(1, 150);
         end else begin
            phase_len = $urandom_range(1, 40);
         end
         send_random_pixels(phase_len);
         sent += phase_len;
      end
   endtask

   // Receiver stalls in modes that change at random intervals
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         stall_timer <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 200);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Outputs settle by the falling edge; a result taken at the next rising edge is checked here
   always @(negedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("result with no pending request");
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("luma", want.luma, rsp_luma);
            check_field("chroma_valid", 8'(want.chroma_valid), 8'(rsp_chroma_valid));
            check_field("chroma_blue", want.chroma_blue, rsp_chroma_blue);
            check_field("chroma_red", want.chroma_red, rsp_chroma_red);
            check_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_color_extremes();
      test_reset_size();
      test_minimum_size();
      test_odd_size();
      test_unused_index();
      test_shrink_mid_frame();
      test_largest_size();
      test_random_frames();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
